// ----- rtl/rtm_pkg.sv -----
// Shared types and constants for the region trigger matcher.
// No dependencies.
package rtm_pkg;
  localparam int unsigned RecDepth = 1024;
  localparam int unsigned SlotDepth = 256;
  localparam int unsigned RecAw = $clog2(RecDepth);
  localparam int unsigned SlotAw = $clog2(SlotDepth);
  localparam int unsigned QDepth = 2;

  localparam logic [1:0] CmdWrRec = 2'd0;
  localparam logic [1:0] CmdWrSlot = 2'd1;
  localparam logic [1:0] CmdMatch = 2'd2;
  localparam logic [1:0] CmdUnused = 2'd3;

  localparam logic [1:0] StOk = 2'd0;
  localparam logic [1:0] StNoMatch = 2'd1;
  localparam logic [1:0] StInvalid = 2'd2;
  localparam logic [1:0] StRange = 2'd3;

  typedef struct packed {
    logic [7:0] rows;
    logic [7:0] flag;
    logic [15:0] first;
    logic [15:0] last;
    logic [15:0] action;
  } rec_t;

  // Classified job handed from front to back.
  typedef struct packed {
    logic walk;
    logic wr;
    rec_t rec;
    logic [1:0] status;
    logic [RecAw-1:0] start;
    logic [10:0] len;
    logic [15:0] pos;
    logic [16:0] stride;
  } job_t;
endpackage

// ----- rtl/rtm_front.sv -----
// Front end: accepts commands, performs slot writes, classifies beats.
// Depends on rtm_pkg.
module rtm_front import rtm_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  output logic busy,
  input  logic [1:0] cmd_i,
  input  logic [9:0] index_i,
  input  logic [7:0] row_count_i,
  input  logic [7:0] flag_index_i,
  input  logic [15:0] first_cell_i,
  input  logic [15:0] last_cell_i,
  input  logic [15:0] action_i,
  input  logic [9:0] list_start_i,
  input  logic [10:0] list_length_i,
  input  logic [15:0] area_flags_i,
  input  logic [15:0] map_width_i,
  input  logic [15:0] actor_cell_i,
  input  logic [8:0] dir_slots_i,
  output logic job_vld_o,
  output job_t job_o,
  input  logic job_full_i
);
  logic [SlotDepth-1:0] slot_vld_q;
  logic [20:0] slot_mem [SlotDepth];
  logic [20:0] slot_rd_q;
  logic pend_q;
  job_t pend_job_q;
  job_t job_d;
  logic acc;
  logic [10:0] slot_w;

  assign busy = pend_q || job_full_i;
  assign acc = start && !busy;
  assign slot_w = area_flags_i[11:1];

  always_ff @(posedge clk_i) begin
    if (acc && cmd_i == CmdWrSlot && {1'b0, index_i} < 11'(SlotDepth)) begin
      slot_mem[index_i[SlotAw-1:0]] <= {list_length_i, list_start_i};
    end
    slot_rd_q <= slot_mem[slot_w[SlotAw-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_vld_q <= '0;
      pend_q <= 1'b0;
    end else begin
      if (acc && cmd_i == CmdWrSlot && {1'b0, index_i} < 11'(SlotDepth)) begin
        slot_vld_q[index_i[SlotAw-1:0]] <= 1'b1;
      end
      if (acc) begin
        pend_q <= 1'b1;
      end else if (pend_q) begin
        pend_q <= 1'b0;
      end
    end
  end

  always_comb begin
    job_d = '0;
    job_d.status = StNoMatch;
    job_d.pos = actor_cell_i;
    job_d.stride = {map_width_i, 1'b0};
    job_d.rec = '{rows: row_count_i, flag: flag_index_i, first: first_cell_i,
                  last: last_cell_i, action: action_i};
    unique case (cmd_i)
      CmdWrRec: begin
        job_d.start = index_i[RecAw-1:0];
        if ({1'b0, index_i} >= 11'(RecDepth)) begin
          job_d.status = StRange;
        end else if (row_count_i == 8'd0 || first_cell_i > last_cell_i) begin
          job_d.status = StInvalid;
        end else begin
          job_d.status = StOk;
          job_d.wr = 1'b1;
        end
      end
      CmdWrSlot: begin
        job_d.status = ({1'b0, index_i} >= 11'(SlotDepth)) ? StRange : StOk;
      end
      CmdMatch: begin
        job_d.walk = !area_flags_i[0] && (slot_w < {2'b0, dir_slots_i})
                     && (slot_w < 11'(SlotDepth))
                     && slot_vld_q[slot_w[SlotAw-1:0]];
      end
      default: job_d.status = StNoMatch;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      pend_job_q <= job_d;
    end
  end

  always_comb begin
    job_o = pend_job_q;
    if (pend_job_q.walk) begin
      job_o.start = slot_rd_q[RecAw-1:0];
      job_o.len = slot_rd_q[20:10];
    end
  end
  assign job_vld_o = pend_q;
endmodule

// ----- rtl/rtm_queue.sv -----
// Short job queue between front and back ends.
// Depends on rtm_pkg.
module rtm_queue import rtm_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t data_i,
  output logic full_o,
  output logic vld_o,
  output job_t data_o,
  input  logic pop_i
);
  job_t mem_q [QDepth];
  logic wp_q, rp_q;
  logic [1:0] cnt_q;

  assign full_o = cnt_q >= 2'(QDepth - 1);
  assign vld_o = cnt_q != 2'd0;
  assign data_o = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wp_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0;
      rp_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wp_q <= !wp_q;
      end
      if (pop_i) begin
        rp_q <= !rp_q;
      end
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i);
    end
  end
endmodule

// ----- rtl/rtm_back.sv -----
// Back end: walks record lists row by row and issues results.
// Holds the record store. Depends on rtm_pkg.
module rtm_back import rtm_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic job_vld_i,
  input  job_t job_i,
  output logic job_pop_o,
  output logic done_o,
  output logic [1:0] status_o,
  output logic [15:0] hit_action_o,
  output logic [7:0] hit_flag_index_o,
  output logic [7:0] hit_row_count_o,
  output logic [15:0] hit_first_cell_o,
  output logic [15:0] hit_last_cell_o
);
  localparam logic [1:0] SIdle = 2'd0;
  localparam logic [1:0] SFetch = 2'd1;
  localparam logic [1:0] SRows = 2'd2;

  rec_t rec_mem [RecDepth];
  rec_t rec_q;
  logic [1:0] st_q;
  job_t job_q;
  logic [RecAw:0] idx_q;
  logic [10:0] left_q;
  logic [7:0] row_q;
  logic [31:0] lo_q, hi_q;
  logic hit, load, more, last_rec, done_d;

  always_ff @(posedge clk_i) begin
    if (st_q == SIdle && job_vld_i && job_i.wr) begin
      rec_mem[job_i.start] <= job_i.rec;
    end
    rec_q <= rec_mem[idx_q[RecAw-1:0]];
  end

  assign hit = {16'd0, job_q.pos} >= lo_q && {16'd0, job_q.pos} <= hi_q;
  assign job_pop_o = st_q == SIdle && job_vld_i;
  assign load = row_q == 8'd0;
  assign more = row_q < rec_q.rows;
  assign last_rec = left_q == 11'd1 || idx_q + 1'b1 >= (RecAw+1)'(RecDepth);

  always_comb begin
    done_d = 1'b0;
    unique case (st_q)
      SIdle: done_d = job_vld_i && !(job_i.walk && job_i.len != 11'd0);
      SRows: done_d = !load && (hit || (!more && last_rec));
      default: done_d = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= SIdle;
      done_o <= 1'b0;
    end else begin
      done_o <= done_d;
      unique case (st_q)
        SIdle: begin
          if (job_vld_i) begin
            job_q <= job_i;
            idx_q <= {1'b0, job_i.start};
            left_q <= job_i.len;
            if (job_i.walk && job_i.len != 11'd0) begin
              st_q <= SFetch;
            end else begin
              status_o <= job_i.status;
              {hit_action_o, hit_flag_index_o, hit_row_count_o} <= '0;
              {hit_first_cell_o, hit_last_cell_o} <= '0;
            end
          end
        end
        SFetch: begin
          // wait for the registered record read data
          st_q <= SRows;
          row_q <= 8'd0;
        end
        SRows: begin
          if (load) begin
            lo_q <= {16'd0, rec_q.first};
            hi_q <= {16'd0, rec_q.last};
            row_q <= 8'd1;
          end else if (hit) begin
            status_o <= StOk;
            hit_action_o <= rec_q.action;
            hit_flag_index_o <= rec_q.flag;
            hit_row_count_o <= rec_q.rows;
            hit_first_cell_o <= rec_q.first;
            hit_last_cell_o <= rec_q.last;
            st_q <= SIdle;
          end else if (more) begin
            lo_q <= lo_q + {15'd0, job_q.stride};
            hi_q <= hi_q + {15'd0, job_q.stride};
            row_q <= row_q + 8'd1;
          end else if (last_rec) begin
            status_o <= StNoMatch;
            {hit_action_o, hit_flag_index_o, hit_row_count_o} <= '0;
            {hit_first_cell_o, hit_last_cell_o} <= '0;
            st_q <= SIdle;
          end else begin
            idx_q <= idx_q + 1'b1;
            left_q <= left_q - 11'd1;
            st_q <= SFetch;
          end
        end
        default: st_q <= SIdle;
      endcase
    end
  end
endmodule

// ----- rtl/region_trigger_match.sv -----
// Region trigger matcher top level: front end, job queue, back end. Depends on
// rtm_pkg, rtm_front, rtm_queue, rtm_back. An accepted beat is registered in the
// front end, passes through the queue and is finished by the back end, which
// registers done_o; a walking query also fetches each record walked and tests its rows, one row a cycle.
// While a walk runs, one more beat waits in the queue and busy is high. Results
// cannot be stalled. Reset clears slot valid bits, the slot count and control state, not the record or slot stores.
module region_trigger_match import rtm_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  output logic busy,
  output logic done_o,
  input  logic cfg_we_i,
  input  logic [8:0] cfg_wdata_i,
  input  logic [1:0] cmd_i,
  input  logic [9:0] index_i,
  input  logic [7:0] row_count_i,
  input  logic [7:0] flag_index_i,
  input  logic [15:0] first_cell_i,
  input  logic [15:0] last_cell_i,
  input  logic [15:0] action_i,
  input  logic [9:0] list_start_i,
  input  logic [10:0] list_length_i,
  input  logic [15:0] area_flags_i,
  input  logic [15:0] actor_cell_i,
  input  logic [15:0] map_width_i,
  output logic [1:0] status_o,
  output logic [15:0] hit_action_o,
  output logic [7:0] hit_flag_index_o,
  output logic [7:0] hit_row_count_o,
  output logic [15:0] hit_first_cell_o,
  output logic [15:0] hit_last_cell_o
);
  logic [8:0] dir_slots_q;
  logic job_vld, q_full, q_vld, q_pop;
  job_t job_in, job_out;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dir_slots_q <= '0;
    end else if (cfg_we_i) begin
      dir_slots_q <= cfg_wdata_i;
    end
  end

  rtm_front u_front (
    .clk_i, .rst_ni, .start, .busy, .cmd_i, .index_i, .row_count_i, .flag_index_i,
    .first_cell_i, .last_cell_i, .action_i, .list_start_i, .list_length_i,
    .area_flags_i, .map_width_i, .actor_cell_i, .dir_slots_i(dir_slots_q),
    .job_vld_o(job_vld), .job_o(job_in), .job_full_i(q_full)
  );

  rtm_queue u_queue (
    .clk_i, .rst_ni, .push_i(job_vld), .data_i(job_in), .full_o(q_full),
    .vld_o(q_vld), .data_o(job_out), .pop_i(q_pop)
  );

  rtm_back u_back (
    .clk_i, .rst_ni, .job_vld_i(q_vld), .job_i(job_out), .job_pop_o(q_pop),
    .done_o, .status_o, .hit_action_o, .hit_flag_index_o, .hit_row_count_o,
    .hit_first_cell_o, .hit_last_cell_o
  );
endmodule
